@@ rtl/assert_macros.svh @@
// assertion macros shared by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every rising clock edge outside reset
`define GLI_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("gli assertion failed");

// expression that must never be true outside reset
`define GLI_ASSERT_NEVER(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("gli assertion failed");

`endif

@@ rtl/gli_pkg.sv @@
// shared types, constants and elaboration-time functions of the guidance line intercept core
// no dependencies
package gli_pkg;

  localparam int CORDIC_STEPS_DEF = 32;

  // word widths
  localparam int CW = 62;   // cordic x, y, z in q.60
  localparam int NW = 112;  // numerator in q.94
  localparam int DW = 61;   // divisor magnitude
  localparam int QW = 64;   // quotient bits

  localparam logic [63:0] PI_Q60         = 64'h3243F6A8885A308D;
  localparam logic [63:0] DEG_TO_RAD_Q44 = PI_Q60 / 64'd11796480;

  localparam int D90  = 90 * 65536;
  localparam int D180 = 180 * 65536;
  localparam int D270 = 270 * 65536;
  localparam int D360 = 360 * 65536;

  localparam logic [63:0] SENTINEL_ICPT = 64'd12345678 << 34;
  localparam logic [63:0] ICPT_MAX      = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] ICPT_MIN      = 64'h8000_0000_0000_0000;

  // item fields that ride along the pipeline
  typedef struct packed {
    logic [26:0] line_heading;
    logic [47:0] pos_x;
    logic [47:0] pos_y;
    logic        vert;
    logic        flag;  // half-plane flip up to the magnitude stage, quotient sign after
  } side_t;

  function automatic logic [63:0] div_odd(input logic [63:0] p, input int k);
    logic [63:0] r;
    case (k)
      0:  r = p;          1:  r = p / 64'd3;  2:  r = p / 64'd5;  3:  r = p / 64'd7;
      4:  r = p / 64'd9;  5:  r = p / 64'd11; 6:  r = p / 64'd13; 7:  r = p / 64'd15;
      8:  r = p / 64'd17; 9:  r = p / 64'd19; 10: r = p / 64'd21; 11: r = p / 64'd23;
      12: r = p / 64'd25; 13: r = p / 64'd27; 14: r = p / 64'd29; 15: r = p / 64'd31;
      16: r = p / 64'd33; 17: r = p / 64'd35; 18: r = p / 64'd37; 19: r = p / 64'd39;
      20: r = p / 64'd41; 21: r = p / 64'd43; 22: r = p / 64'd45; 23: r = p / 64'd47;
      24: r = p / 64'd49; 25: r = p / 64'd51; 26: r = p / 64'd53; 27: r = p / 64'd55;
      28: r = p / 64'd57; 29: r = p / 64'd59; 30: r = p / 64'd61; 31: r = p / 64'd63;
      default: r = 64'd0;
    endcase
    return r;
  endfunction

  // atan(2^-i) in q.60 from a truncated taylor series in q.62
  function automatic logic [63:0] atan_q60(input int i);
    logic [63:0] p;
    logic [63:0] sum;
    logic [63:0] t;
    int          sh;
    if (i == 0) return PI_Q60 >> 2;
    if (i >= 62) return 64'd0;
    p   = 64'd1 << (62 - i);
    sum = 64'd0;
    sh  = 2 * i;
    for (int k = 0; k < 32; k++) begin
      if (p != 64'd0) begin
        t = div_odd(p, k);
        if (k[0]) sum = sum - t;
        else sum = sum + t;
        p = (sh < 64) ? (p >> sh) : 64'd0;
      end
    end
    return (sum + 64'd2) >> 2;
  endfunction

  // x output of the rotation run at angle zero
  function automatic logic signed [63:0] cordic_gain(input int steps);
    logic signed [63:0] x;
    logic signed [63:0] y;
    logic signed [63:0] z;
    logic signed [63:0] xs;
    logic signed [63:0] ys;
    logic signed [63:0] a;
    x = 64'sd1 <<< 60;
    y = 64'sd0;
    z = 64'sd0;
    for (int i = 0; i < steps; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      a  = $signed(atan_q60(i));
      if (z >= 0) begin
        x = x - ys; y = y + xs; z = z - a;
      end else begin
        x = x + ys; y = y - xs; z = z + a;
      end
    end
    return x;
  endfunction

endpackage

@@ rtl/guidance_line_intercept_core.sv @@
// guidance line intercept core: heading wrap, cordic, products, divider and output skid
// depends on gli_pkg, gli_cordic, gli_div
//
//   channel   | direction | beat
//   s_axis    | in        | tdata: pos_x, pos_y, heading_deg
//   m_axis    | out       | tdata: line_heading, intercept, anchor_x, anchor_y; tuser: flags
//   apb       | in/out    | reg 0 heading_offset at 0x0, reg 1 lateral_offset at 0x4
//
// one beat per cycle sustained while the skid stage is empty
// pipeline depth is set by one cordic micro-rotation and one quotient bit per stage
// reset clears valid bits and the registers only, no clearing pass
// every stage advances together; the pipeline halts only while the skid stage is full,
// so an input beat is still taken while a finished result waits at m_axis
module guidance_line_intercept_core #(
  parameter int CORDIC_STEPS = gli_pkg::CORDIC_STEPS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // input stream
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,   // pos_x[47:0], pos_y[95:48], heading_deg[121:96]
  // result stream
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [191:0] m_axis_tdata,   // line_heading[26:0], intercept[90:27],
                                       // anchor_x[138:91], anchor_y[186:139]
  output logic [1:0]   m_axis_tuser,   // is_vertical[0], saturated[1]
  // configuration
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam int CW = gli_pkg::CW;
  localparam int NW = gli_pkg::NW;
  localparam int DW = gli_pkg::DW;
  localparam int QW = gli_pkg::QW;

  localparam logic signed [63:0] Gain   = gli_pkg::cordic_gain(CORDIC_STEPS);
  localparam logic signed [31:0] GainHi = {1'b0, Gain[61:31]};
  localparam logic signed [31:0] GainLo = {1'b0, Gain[30:0]};
  localparam logic signed [39:0] D2r    = {1'b0, gli_pkg::DEG_TO_RAD_Q44[38:0]};

  typedef enum logic [0:0] {
    REG_HEADING_OFFSET = 1'b0,
    REG_LATERAL_OFFSET = 1'b1
  } reg_idx_e;

  // ---------------------------------------------------------------- config
  logic [25:0] hoff_q;
  logic [31:0] lat_q;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hoff_q <= '0;
      lat_q  <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx_e'(paddr[2]))
        REG_HEADING_OFFSET: hoff_q <= pwdata[25:0];
        REG_LATERAL_OFFSET: lat_q  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx_e'(paddr[2]))
      REG_HEADING_OFFSET: prdata = {{6{hoff_q[25]}}, hoff_q};
      REG_LATERAL_OFFSET: prdata = lat_q;
      default:            prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- flow control
  // whole pipeline moves while the skid stage is empty
  logic skid_v_q;
  logic en;

  assign en            = !skid_v_q;
  assign s_axis_tready = en;

  // ---------------------------------------------------------------- s1: wrap
  logic signed [26:0] theta;
  logic signed [25:0] t_wrap;
  logic signed [28:0] cand;
  logic signed [25:0] phi_full;
  logic               vert, flip;

  always_comb begin
    theta  = $signed({s_axis_tdata[121], s_axis_tdata[121:96]})
           - $signed({hoff_q[25], hoff_q});
    t_wrap = theta[25:0];
    cand   = '0;
    // at most three turns of 360 away from the window
    for (int k = -3; k <= 3; k++) begin
      cand = $signed({{2{theta[26]}}, theta}) + 29'(k * gli_pkg::D360);
      if (cand >= -gli_pkg::D90 && cand <= gli_pkg::D270) t_wrap = cand[25:0];
    end
    vert = (t_wrap == 26'(-gli_pkg::D90)) || (t_wrap == 26'(gli_pkg::D90))
        || (t_wrap == 26'(gli_pkg::D270));
    flip = t_wrap > 26'(gli_pkg::D90);
    phi_full = flip ? t_wrap - 26'(gli_pkg::D180) : t_wrap;
  end

  logic               s1_v_q;
  gli_pkg::side_t     s1_side_q;
  logic signed [23:0] s1_phi_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (en) begin
      s1_v_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_side_q.line_heading <= theta;
      s1_side_q.pos_x        <= s_axis_tdata[47:0];
      s1_side_q.pos_y        <= s_axis_tdata[95:48];
      s1_side_q.vert         <= vert;
      s1_side_q.flag         <= flip;
      s1_phi_q               <= phi_full[23:0];
    end
  end

  // ---------------------------------------------------------------- s2: degrees to radians
  logic signed [63:0]   z_full;
  logic                 s2_v_q;
  gli_pkg::side_t       s2_side_q;
  logic signed [CW-1:0] s2_z_q;

  assign z_full = s1_phi_q * D2r;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (en) begin
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_side_q <= s1_side_q;
      s2_z_q    <= z_full[CW-1:0];
    end
  end

  // ---------------------------------------------------------------- cordic
  logic                 cr_v;
  gli_pkg::side_t       cr_side;
  logic signed [CW-1:0] cr_c, cr_s;

  gli_cordic #(
    .Steps (CORDIC_STEPS)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s2_v_q),
    .side_i  (s2_side_q),
    .z_i     (s2_z_q),
    .valid_o (cr_v),
    .side_o  (cr_side),
    .c_o     (cr_c),
    .s_o     (cr_s)
  );

  // ---------------------------------------------------------------- s3: half-plane flip
  logic                 s3_v_q;
  gli_pkg::side_t       s3_side_q;
  logic signed [CW-1:0] s3_c_q, s3_s_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_v_q <= 1'b0;
    end else if (en) begin
      s3_v_q <= cr_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_side_q <= cr_side;
      s3_c_q    <= cr_side.flag ? -cr_c : cr_c;
      s3_s_q    <= cr_side.flag ? -cr_s : cr_s;
    end
  end

  // ---------------------------------------------------------------- s4: partial products
  // a = a_hi*2^24 + a_lo, b = b_hi*2^31 + b_lo, each product at most 25 x 32
  logic signed [23:0] py_hi, px_hi;
  logic signed [24:0] py_lo, px_lo;
  logic signed [30:0] c_hi, s_hi;
  logic signed [31:0] c_lo, s_lo;

  assign py_hi = s3_side_q.pos_y[47:24];
  assign py_lo = {1'b0, s3_side_q.pos_y[23:0]};
  assign px_hi = s3_side_q.pos_x[47:24];
  assign px_lo = {1'b0, s3_side_q.pos_x[23:0]};
  assign c_hi  = s3_c_q[61:31];
  assign c_lo  = {1'b0, s3_c_q[30:0]};
  assign s_hi  = s3_s_q[61:31];
  assign s_lo  = {1'b0, s3_s_q[30:0]};

  logic                 s4_v_q;
  gli_pkg::side_t       s4_side_q;
  logic signed [CW-1:0] s4_c_q;
  logic signed [56:0]   s4_yc_hh_q, s4_yc_hl_q, s4_yc_lh_q, s4_yc_ll_q;
  logic signed [56:0]   s4_xs_hh_q, s4_xs_hl_q, s4_xs_lh_q, s4_xs_ll_q;
  logic signed [63:0]   s4_lg_hi_q, s4_lg_lo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_v_q <= 1'b0;
    end else if (en) begin
      s4_v_q <= s3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s4_side_q  <= s3_side_q;
      s4_c_q     <= s3_c_q;
      s4_yc_hh_q <= py_hi * c_hi;
      s4_yc_hl_q <= py_hi * c_lo;
      s4_yc_lh_q <= py_lo * c_hi;
      s4_yc_ll_q <= py_lo * c_lo;
      s4_xs_hh_q <= px_hi * s_hi;
      s4_xs_hl_q <= px_hi * s_lo;
      s4_xs_lh_q <= px_lo * s_hi;
      s4_xs_ll_q <= px_lo * s_lo;
      s4_lg_hi_q <= $signed(lat_q) * GainHi;
      s4_lg_lo_q <= $signed(lat_q) * GainLo;
    end
  end

  // ---------------------------------------------------------------- s5: product sums
  logic signed [NW-1:0] yc_sum, xs_sum, lg_sum;

  assign yc_sum = (NW'(s4_yc_hh_q) <<< 55) + (NW'(s4_yc_hl_q) <<< 24)
                + (NW'(s4_yc_lh_q) <<< 31) + NW'(s4_yc_ll_q);
  assign xs_sum = (NW'(s4_xs_hh_q) <<< 55) + (NW'(s4_xs_hl_q) <<< 24)
                + (NW'(s4_xs_lh_q) <<< 31) + NW'(s4_xs_ll_q);
  // lateral offset times gain, aligned from q.76 to q.94
  assign lg_sum = ((NW'(s4_lg_hi_q) <<< 31) + NW'(s4_lg_lo_q)) <<< 18;

  logic                 s5_v_q;
  gli_pkg::side_t       s5_side_q;
  logic signed [CW-1:0] s5_c_q;
  logic signed [NW-1:0] s5_yc_q, s5_xs_q, s5_lg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s5_v_q <= 1'b0;
    end else if (en) begin
      s5_v_q <= s4_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s5_side_q <= s4_side_q;
      s5_c_q    <= s4_c_q;
      s5_yc_q   <= yc_sum;
      s5_xs_q   <= xs_sum;
      s5_lg_q   <= lg_sum;
    end
  end

  // ---------------------------------------------------------------- s6: numerator
  logic                 s6_v_q;
  gli_pkg::side_t       s6_side_q;
  logic signed [CW-1:0] s6_c_q;
  logic signed [NW-1:0] s6_n_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s6_v_q <= 1'b0;
    end else if (en) begin
      s6_v_q <= s5_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s6_side_q <= s5_side_q;
      s6_c_q    <= s5_c_q;
      s6_n_q    <= s5_lg_q + s5_yc_q - s5_xs_q;
    end
  end

  // ---------------------------------------------------------------- s7: magnitudes, rounding
  logic                 nneg;
  logic [CW-1:0]        c_mag;
  logic [DW-1:0]        dm;
  logic [NW-1:0]        num_rnd;
  gli_pkg::side_t       side7;

  always_comb begin
    nneg  = s6_n_q[NW-1];
    c_mag = s6_c_q[CW-1] ? -s6_c_q : s6_c_q;
    dm    = c_mag[DW-1:0];
    // |n| + dm/2, negation folded into one add
    num_rnd = (nneg ? ~s6_n_q : s6_n_q) + NW'(dm >> 1) + NW'(nneg);
    side7      = s6_side_q;
    side7.flag = nneg ^ s6_c_q[CW-1];
  end

  logic                 s7_v_q;
  gli_pkg::side_t       s7_side_q;
  logic [NW-1:0]        s7_num_q;
  logic [DW-1:0]        s7_den_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s7_v_q <= 1'b0;
    end else if (en) begin
      s7_v_q <= s6_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s7_side_q <= side7;
      s7_num_q  <= num_rnd;
      s7_den_q  <= dm;
    end
  end

  // ---------------------------------------------------------------- divider
  logic           dv_v;
  gli_pkg::side_t dv_side;
  logic           dv_ovf;
  logic [QW-1:0]  dv_quo;

  gli_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s7_v_q),
    .side_i  (s7_side_q),
    .num_i   (s7_num_q),
    .den_i   (s7_den_q),
    .valid_o (dv_v),
    .side_o  (dv_side),
    .ovf_o   (dv_ovf),
    .quo_o   (dv_quo)
  );

  // ---------------------------------------------------------------- result select
  logic [63:0]  icpt;
  logic         sat;
  logic [191:0] res_data;
  logic [1:0]   res_user;

  always_comb begin
    sat  = 1'b0;
    icpt = dv_quo;
    if (dv_side.vert) begin
      icpt = gli_pkg::SENTINEL_ICPT;
    end else if (dv_ovf) begin
      // also covers a zero cosine
      sat  = 1'b1;
      icpt = dv_side.flag ? gli_pkg::ICPT_MIN : gli_pkg::ICPT_MAX;
    end else if (dv_side.flag) begin
      if (dv_quo > gli_pkg::ICPT_MIN) begin
        sat  = 1'b1;
        icpt = gli_pkg::ICPT_MIN;
      end else begin
        icpt = -dv_quo;
      end
    end else if (dv_quo[QW-1]) begin
      sat  = 1'b1;
      icpt = gli_pkg::ICPT_MAX;
    end
    res_data = {5'b0, dv_side.pos_y, dv_side.pos_x, icpt, dv_side.line_heading};
    res_user = {sat, dv_side.vert};
  end

  // ---------------------------------------------------------------- output register and skid
  logic         take;
  logic         out_free;
  logic         out_v_q;
  logic [191:0] out_data_q, skid_data_q;
  logic [1:0]   out_user_q, skid_user_q;

  assign take     = en && dv_v;
  assign out_free = !out_v_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (out_free) begin
      if (skid_v_q) begin
        out_v_q  <= 1'b1;
        skid_v_q <= 1'b0;
      end else begin
        out_v_q  <= take;
      end
    end else if (take) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_data_q <= skid_v_q ? skid_data_q : res_data;
      out_user_q <= skid_v_q ? skid_user_q : res_user;
    end else if (take) begin
      skid_data_q <= res_data;
      skid_user_q <= res_user;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

endmodule

@@ rtl/gli_cordic.sv @@
// rotation-mode cordic, one micro-rotation per register stage
// depends on gli_pkg
module gli_cordic #(
  parameter int Steps = gli_pkg::CORDIC_STEPS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  gli_pkg::side_t                side_i,
  input  logic signed [gli_pkg::CW-1:0] z_i,
  output logic                          valid_o,
  output gli_pkg::side_t                side_o,
  output logic signed [gli_pkg::CW-1:0] c_o,
  output logic signed [gli_pkg::CW-1:0] s_o
);

  localparam int CW = gli_pkg::CW;
  localparam logic signed [CW-1:0] One = {{(CW-61){1'b0}}, 1'b1, 60'b0};

  logic                 v_q    [Steps];
  gli_pkg::side_t       side_q [Steps];
  logic signed [CW-1:0] x_q    [Steps];
  logic signed [CW-1:0] y_q    [Steps];
  logic signed [CW-1:0] z_q    [Steps];

  for (genvar i = 0; i < Steps; i++) begin : g_step
    localparam logic [63:0] AtanFull = gli_pkg::atan_q60(i);
    localparam logic signed [CW-1:0] Atan = AtanFull[CW-1:0];

    logic                 vin;
    gli_pkg::side_t       sin;
    logic signed [CW-1:0] xin, yin, zin, x_d, y_d, z_d;

    if (i == 0) begin : g_first
      assign vin = valid_i;
      assign sin = side_i;
      assign xin = One;
      assign yin = '0;
      assign zin = z_i;
    end else begin : g_next
      assign vin = v_q[i-1];
      assign sin = side_q[i-1];
      assign xin = x_q[i-1];
      assign yin = y_q[i-1];
      assign zin = z_q[i-1];
    end

    always_comb begin
      if (!zin[CW-1]) begin
        x_d = xin - (yin >>> i);
        y_d = yin + (xin >>> i);
        z_d = zin - Atan;
      end else begin
        x_d = xin + (yin >>> i);
        y_d = yin - (xin >>> i);
        z_d = zin + Atan;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i] <= 1'b0;
      end else if (en_i) begin
        v_q[i] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_q[i] <= sin;
        x_q[i]    <= x_d;
        y_q[i]    <= y_d;
        z_q[i]    <= z_d;
      end
    end
  end

  assign valid_o = v_q[Steps-1];
  assign side_o  = side_q[Steps-1];
  assign c_o     = x_q[Steps-1];
  assign s_o     = y_q[Steps-1];

endmodule

@@ rtl/gli_div.sv @@
// pipelined restoring divider, one quotient bit per register stage, with overflow check
// depends on gli_pkg
module gli_div (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  gli_pkg::side_t         side_i,
  input  logic [gli_pkg::NW-1:0] num_i,
  input  logic [gli_pkg::DW-1:0] den_i,
  output logic                   valid_o,
  output gli_pkg::side_t         side_o,
  output logic                   ovf_o,
  output logic [gli_pkg::QW-1:0] quo_o
);

  localparam int NW = gli_pkg::NW;
  localparam int DW = gli_pkg::DW;
  localparam int QW = gli_pkg::QW;

  // entry stage: quotient of 2^QW or more cannot be shown
  logic                 v0_q;
  gli_pkg::side_t       side0_q;
  logic                 ovf0_q;
  logic [DW-1:0]        rem0_q;
  logic [QW-1:0]        lo0_q;
  logic [DW-1:0]        den0_q;

  logic                 v_q    [QW];
  gli_pkg::side_t       side_q [QW];
  logic                 ovf_q  [QW];
  logic [DW-1:0]        rem_q  [QW];
  logic [QW-1:0]        lo_q   [QW];  // low numerator bits shift out, quotient bits shift in
  logic [DW-1:0]        den_q  [QW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (en_i) begin
      v0_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side0_q <= side_i;
      ovf0_q  <= {{(DW-(NW-QW)){1'b0}}, num_i[NW-1:QW]} >= den_i;
      rem0_q  <= {{(DW-(NW-QW)){1'b0}}, num_i[NW-1:QW]};
      lo0_q   <= num_i[QW-1:0];
      den0_q  <= den_i;
    end
  end

  for (genvar j = 0; j < QW; j++) begin : g_bit
    logic           vin, oin;
    gli_pkg::side_t sin;
    logic [DW-1:0]  rin, din;
    logic [QW-1:0]  lin;
    logic [DW:0]    r2, diff;
    logic           ge;

    if (j == 0) begin : g_first
      assign vin = v0_q;
      assign sin = side0_q;
      assign oin = ovf0_q;
      assign rin = rem0_q;
      assign lin = lo0_q;
      assign din = den0_q;
    end else begin : g_next
      assign vin = v_q[j-1];
      assign sin = side_q[j-1];
      assign oin = ovf_q[j-1];
      assign rin = rem_q[j-1];
      assign lin = lo_q[j-1];
      assign din = den_q[j-1];
    end

    assign r2   = {rin, lin[QW-1]};
    assign ge   = r2 >= {1'b0, din};
    assign diff = r2 - {1'b0, din};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[j] <= 1'b0;
      end else if (en_i) begin
        v_q[j] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_q[j] <= sin;
        ovf_q[j]  <= oin;
        rem_q[j]  <= ge ? diff[DW-1:0] : r2[DW-1:0];
        lo_q[j]   <= {lin[QW-2:0], ge};
        den_q[j]  <= din;
      end
    end
  end

  assign valid_o = v_q[QW-1];
  assign side_o  = side_q[QW-1];
  assign ovf_o   = ovf_q[QW-1];
  assign quo_o   = lo_q[QW-1];

endmodule

@@ rtl/gli_checker.sv @@
// port-level checks of the guidance line intercept core, bound to the top level
// depends on gli_pkg, assert_macros.svh, guidance_line_intercept_core
`include "assert_macros.svh"

module gli_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [191:0] m_axis_tdata,
  input logic [1:0]   m_axis_tuser
);

  logic [63:0] icpt;
  assign icpt = m_axis_tdata[90:27];

  // a stalled result beat holds
  `GLI_ASSERT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

  // vertical lines never saturate
  `GLI_ASSERT_NEVER(a_vert_not_sat, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser[0] && m_axis_tuser[1])

  // vertical lines carry the sentinel
  `GLI_ASSERT(a_vert_sentinel, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser[0] |-> icpt == gli_pkg::SENTINEL_ICPT)

  // a saturated intercept sits on a rail
  `GLI_ASSERT(a_sat_rail, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser[1] |-> icpt == gli_pkg::ICPT_MAX || icpt == gli_pkg::ICPT_MIN)

endmodule

bind guidance_line_intercept_core gli_checker u_gli_checker (.*);
